[design/tpa_pkg.sv]
// Shared widths and queue depth for the triangle perimeter and area block.
package tpa_pkg;

	localparam int PERIM_W    = 27;
	localparam int AREA_W     = 32;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

endpackage

[design/tpa_front.sv]
// Front pipeline: edge deltas, squares and their sums, cross product and its absolute value.
module tpa_front #(
	parameter int COORD_BITS = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic        [COORD_BITS-1:0]              first_x,
	input  logic        [COORD_BITS-1:0]              first_y,
	input  logic        [COORD_BITS-1:0]              second_x,
	input  logic        [COORD_BITS-1:0]              second_y,
	input  logic        [COORD_BITS-1:0]              third_x,
	input  logic        [COORD_BITS-1:0]              third_y,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic [2:0][2*COORD_BITS:0]                out_sums,
	output logic        [tpa_pkg::AREA_W-1:0]         out_area
);
	import tpa_pkg::*;

	localparam int C   = COORD_BITS;
	localparam int XW  = 2*C + 2;
	localparam int AWW = (XW > AREA_W) ? XW : AREA_W;

	logic              en;
	logic              v_s1, v_s2, v_s3;
	logic [5:0][C-1:0] mag_s1;
	logic [C:0]        e1x_s1, e1y_s1, e2x_s1, e2y_s1;
	logic [5:0][2*C-1:0] sq_s2;
	logic signed [XW-1:0] p1_s2, p2_s2;
	logic [2:0][2*C:0] sum_s3;
	logic [AREA_W-1:0] area_s3;

	logic [C:0] d_ab_x, d_ab_y, d_bc_x, d_bc_y, d_ca_x, d_ca_y, d_ac_x, d_ac_y;
	logic [XW:0]       cross_d;
	logic [XW:0]       cross_abs;
	logic [AWW-1:0]    area_wide;

	function automatic logic [C-1:0] mag(input logic [C:0] d);
		logic [C:0] n;
		n = d[C] ? (~d + 1'b1) : d;
		return n[C-1:0];
	endfunction

	assign en        = !v_s3 || out_ready;
	assign in_ready  = en;
	assign out_valid = v_s3;
	assign out_sums  = sum_s3;
	assign out_area  = area_s3;

	always_comb begin
		d_ab_x = {second_x[C-1], second_x} - {first_x[C-1], first_x};
		d_ab_y = {second_y[C-1], second_y} - {first_y[C-1], first_y};
		d_bc_x = {third_x[C-1], third_x} - {second_x[C-1], second_x};
		d_bc_y = {third_y[C-1], third_y} - {second_y[C-1], second_y};
		d_ca_x = {first_x[C-1], first_x} - {third_x[C-1], third_x};
		d_ca_y = {first_y[C-1], first_y} - {third_y[C-1], third_y};
		d_ac_x = {third_x[C-1], third_x} - {first_x[C-1], first_x};
		d_ac_y = {third_y[C-1], third_y} - {first_y[C-1], first_y};
	end

	always_comb begin
		cross_d   = {p1_s2[XW-1], p1_s2} - {p2_s2[XW-1], p2_s2};
		cross_abs = cross_d[XW] ? (~cross_d + 1'b1) : cross_d;
		area_wide = AWW'(cross_abs[XW-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= {mag(d_ca_y), mag(d_ca_x), mag(d_bc_y), mag(d_bc_x),
				mag(d_ab_y), mag(d_ab_x)};
			e1x_s1 <= d_ab_x;
			e1y_s1 <= d_ab_y;
			e2x_s1 <= d_ac_x;
			e2y_s1 <= d_ac_y;
			for (int i = 0; i < 6; i++) begin
				sq_s2[i] <= mag_s1[i] * mag_s1[i];
			end
			p1_s2 <= $signed(e1x_s1) * $signed(e2y_s1);
			p2_s2 <= $signed(e1y_s1) * $signed(e2x_s1);
			for (int i = 0; i < 3; i++) begin
				sum_s3[i] <= {1'b0, sq_s2[2*i]} + {1'b0, sq_s2[2*i+1]};
			end
			area_s3 <= area_wide[AREA_W-1:0];
		end
	end

endmodule

[design/tpa_fifo.sv]
// Short queue between the front and back pipelines.
module tpa_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);
	import tpa_pkg::*;

	logic [WIDTH-1:0]   slot_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               push, pop;

	assign in_ready  = count_q != (FIFO_AW+1)'(FIFO_DEPTH);
	assign out_valid = count_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= in_data;
	end

endmodule

[design/tpa_back.sv]
// Back pipeline: three square-root lanes, one result bit per stage, then the perimeter sum.
module tpa_back #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [2:0][2*COORD_BITS:0]         in_sums,
	input  logic [tpa_pkg::AREA_W-1:0]         in_area,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [tpa_pkg::PERIM_W-1:0]        perimeter_len,
	output logic [tpa_pkg::AREA_W-1:0]         twice_area
);
	import tpa_pkg::*;

	localparam int N    = COORD_BITS + 1 + FRAC_BITS;
	localparam int RADW = 2*N;
	localparam int SUMW = (N + 2 > PERIM_W) ? N + 2 : PERIM_W;

	logic                    en;
	logic                    v_s [0:N];
	logic [2:0][RADW-1:0]    rad_s  [0:N];
	logic [2:0][N+1:0]       rem_s  [0:N];
	logic [2:0][N-1:0]       root_s [0:N];
	logic [AREA_W-1:0]       area_s [0:N];
	logic [2:0][RADW-1:0]    rad_nx  [0:N-1];
	logic [2:0][N+1:0]       rem_nx  [0:N-1];
	logic [2:0][N-1:0]       root_nx [0:N-1];
	logic                    v_out_q;
	logic [SUMW-1:0]         perim_sum;

	assign en        = !v_out_q || out_ready;
	assign in_ready  = en;
	assign out_valid = v_out_q;

	// One restoring square-root step per stage and lane.
	always_comb begin
		logic [N+1:0] remx;
		logic [N+1:0] trial;
		for (int k = 0; k < N; k++) begin
			for (int l = 0; l < 3; l++) begin
				remx  = {rem_s[k][l][N-1:0], rad_s[k][l][RADW-1 -: 2]};
				trial = {root_s[k][l], 2'b01};
				rad_nx[k][l] = rad_s[k][l] << 2;
				if (remx >= trial) begin
					rem_nx[k][l]  = remx - trial;
					root_nx[k][l] = {root_s[k][l][N-2:0], 1'b1};
				end else begin
					rem_nx[k][l]  = remx;
					root_nx[k][l] = {root_s[k][l][N-2:0], 1'b0};
				end
			end
		end
	end

	assign perim_sum = SUMW'(root_s[N][0]) + SUMW'(root_s[N][1]) + SUMW'(root_s[N][2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= N; k++) v_s[k] <= 1'b0;
			v_out_q <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int k = 0; k < N; k++) v_s[k+1] <= v_s[k];
			v_out_q <= v_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				rad_s[0][l]  <= RADW'(in_sums[l]) << (2*FRAC_BITS);
				rem_s[0][l]  <= '0;
				root_s[0][l] <= '0;
			end
			area_s[0] <= in_area;
			for (int k = 0; k < N; k++) begin
				rad_s[k+1]  <= rad_nx[k];
				rem_s[k+1]  <= rem_nx[k];
				root_s[k+1] <= root_nx[k];
				area_s[k+1] <= area_s[k];
			end
			perimeter_len <= perim_sum[PERIM_W-1:0];
			twice_area    <= area_s[N];
		end
	end

endmodule

[design/triangle_perimeter_area.sv]
// Top level: triangle perimeter and twice-area, front pipeline, queue, square-root back end.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------------
//   tri      | tri_valid/tri_ready  | first_x first_y second_x second_y third_x third_y
//   res      | res_valid/res_ready  | perimeter_len twice_area
//
// One item enters per cycle while tri_ready is high. The path is 3 front stages, the queue,
// then COORD_BITS+FRAC_BITS+3 back stages (one stage per root bit, 25 for defaults,
// plus input and output registers).
// arst_n clears all valid bits and the queue pointers; payload registers are not reset.
// A stalled result holds the back pipeline; the queue absorbs up to four items before
// the front pipeline and then tri_ready drop.
module triangle_perimeter_area #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               tri_valid,
	output logic                               tri_ready,
	input  logic [COORD_BITS-1:0]              first_x,
	input  logic [COORD_BITS-1:0]              first_y,
	input  logic [COORD_BITS-1:0]              second_x,
	input  logic [COORD_BITS-1:0]              second_y,
	input  logic [COORD_BITS-1:0]              third_x,
	input  logic [COORD_BITS-1:0]              third_y,
	output logic                               res_valid,
	input  logic                               res_ready,
	output logic [tpa_pkg::PERIM_W-1:0]        perimeter_len,
	output logic [tpa_pkg::AREA_W-1:0]         twice_area
);
	import tpa_pkg::*;

	localparam int SW = 2*COORD_BITS + 1;
	localparam int QW = 3*SW + AREA_W;

	// Front to queue.
	logic              push_valid, push_ready;
	logic [2:0][SW-1:0] f_sums;
	logic [AREA_W-1:0]  f_area;
	// Queue to back.
	logic              pop_valid, pop_ready;
	logic [QW-1:0]     q_data;
	logic [2:0][SW-1:0] b_sums;
	logic [AREA_W-1:0]  b_area;

	tpa_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.first_x(first_x), .first_y(first_y),
		.second_x(second_x), .second_y(second_y),
		.third_x(third_x), .third_y(third_y),
		.in_valid(tri_valid), .in_ready(tri_ready),
		.out_valid(push_valid), .out_ready(push_ready),
		.out_sums(f_sums), .out_area(f_area)
	);

	tpa_fifo #(.WIDTH(QW)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.in_valid(push_valid), .in_ready(push_ready), .in_data({f_sums, f_area}),
		.out_valid(pop_valid), .out_ready(pop_ready), .out_data(q_data)
	);

	// Unpack the queued item.
	assign {b_sums, b_area} = q_data;

	tpa_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(pop_valid), .in_ready(pop_ready),
		.in_sums(b_sums), .in_area(b_area),
		.out_valid(res_valid), .out_ready(res_ready),
		.perimeter_len(perimeter_len), .twice_area(twice_area)
	);

`ifndef SYNTHESIS
	// The input side stalls only when the front end holds an item the queue refuses.
	a_front_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!tri_ready |-> (push_valid && !push_ready))
		else $error("input stalled without a full queue");

	// A waiting result freezes the back pipeline, so nothing leaves the queue.
	a_back_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |-> !pop_ready)
		else $error("queue popped while result stalled");

	// The queue empties only through a pop.
	a_queue_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(pop_valid) |-> $past(pop_ready))
		else $error("queue lost an item");
`endif

endmodule
